### hdl/batch_norm_inference_stream_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the batch normalisation block
// Shared wrappers that keep each concurrent assertion on a single line.
// ----------------------------------------------------------------------------
`ifndef BATCH_NORM_INFERENCE_STREAM_TOP_ASSERT_SVH
`define BATCH_NORM_INFERENCE_STREAM_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BNIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BNIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// As above, but also checked while reset is applied.
`define BNIS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bnis_pkg.sv
// ----------------------------------------------------------------------------
// Batch normalisation package
// Request types, register indexes and saturation helper.
// ----------------------------------------------------------------------------
package bnis_pkg;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_PIXELS   = 2'd1;
  localparam logic [1:0] REG_EPSILON  = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         channel_index;
    logic signed [31:0] gamma_value;
    logic signed [31:0] beta_value;
    logic signed [31:0] mean_value;
    logic [30:0]        variance_value;
    logic signed [31:0] sample;
  } bnis_in_t;

  typedef struct packed {
    logic signed [31:0] normalized;
    logic [5:0]         out_channel;
    logic               pixel_end;
    logic               frame_end;
  } bnis_out_t;

  typedef struct packed {
    logic               mode;
    logic [5:0]         ch;
    logic signed [31:0] gamma_value;
    logic signed [31:0] beta_value;
    logic signed [31:0] mean_value;
    logic [30:0]        variance_value;
    logic signed [31:0] sample;
    logic               pixel_end;
    logic               frame_end;
  } bnis_job_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### hdl/bnis_front.sv
// ----------------------------------------------------------------------------
// Batch normalisation front end
// Holds the registers, accepts requests and tags samples with their position.
// ----------------------------------------------------------------------------
module bnis_front #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bnis_pkg::bnis_in_t in_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_data,
  input  logic               q_full,
  output logic               push,
  output bnis_pkg::bnis_job_t push_job,
  output logic [16:0]        eps
);
  import bnis_pkg::*;

  localparam int CHAN_TOP = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;

  logic [6:0]  channels_in_use;
  logic [24:0] pixels_per_frame;
  logic [16:0] epsilon;
  logic [5:0]  chan_pos;
  logic [23:0] pix_pos;
  logic [6:0]  cl;
  logic [24:0] pl;
  logic        pend;
  logic        fend;
  logic        accept;
  logic        in_table;

  always_comb begin
    cl = channels_in_use;
    if (cl == 7'd0) begin
      cl = 7'd1;
    end
    if (cl > 7'(CHAN_TOP)) begin
      cl = 7'(CHAN_TOP);
    end
    pl = pixels_per_frame;
    if (pl == 25'd0) begin
      pl = 25'd1;
    end
    if (pl > 25'h1000000) begin
      pl = 25'h1000000;
    end
  end

  assign pend     = ({1'b0, chan_pos} + 7'd1) >= cl;
  assign fend     = pend && (({1'b0, pix_pos} + 25'd1) >= pl);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_table = 32'(in_data.channel_index) < MAX_CHANNELS;
  assign push     = accept && (in_data.mode == MODE_SAMPLE || in_table);
  assign eps      = (epsilon > 17'h10000) ? 17'h10000 : epsilon;

  always_comb begin
    push_job.mode           = in_data.mode;
    push_job.ch             = (in_data.mode == MODE_SAMPLE) ? chan_pos : in_data.channel_index;
    push_job.gamma_value    = in_data.gamma_value;
    push_job.beta_value     = in_data.beta_value;
    push_job.mean_value     = in_data.mean_value;
    push_job.variance_value = in_data.variance_value;
    push_job.sample         = in_data.sample;
    push_job.pixel_end      = pend;
    push_job.frame_end      = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use  <= 7'd64;
      pixels_per_frame <= 25'd1;
      epsilon          <= 17'd66;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNELS: channels_in_use  <= cfg_data[6:0];
        REG_PIXELS:   pixels_per_frame <= cfg_data;
        REG_EPSILON:  epsilon          <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_pos <= '0;
      pix_pos  <= '0;
    end else if (accept && in_data.mode == MODE_SAMPLE) begin
      if (pend) begin
        chan_pos <= '0;
        pix_pos  <= fend ? '0 : pix_pos + 24'd1;
      end else begin
        chan_pos <= chan_pos + 6'd1;
      end
    end
  end

endmodule

### hdl/bnis_queue.sv
// ----------------------------------------------------------------------------
// Batch normalisation request queue
// Four-entry queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module bnis_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bnis_pkg::bnis_job_t push_job,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output bnis_pkg::bnis_job_t head
);
  import bnis_pkg::*;

  bnis_job_t  slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full  = count == 3'd4;
  assign empty = count == 3'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

### hdl/bnis_back.sv
// ----------------------------------------------------------------------------
// Batch normalisation back end
// Works out scale and shift for loads, and the multiply-add for samples.
// ----------------------------------------------------------------------------
module bnis_back #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  bnis_pkg::bnis_job_t head,
  output logic                pop,
  input  logic [16:0]         eps,
  output logic                out_valid,
  input  logic                out_stall,
  output bnis_pkg::bnis_out_t out_data
);
  import bnis_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SQRT    = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_SHIFT   = 3'd4;
  localparam logic [2:0] ST_SMP_MUL = 3'd5;
  localparam logic [2:0] ST_SMP_ADD = 3'd6;

  logic [2:0]         state;
  logic [5:0]         step;
  bnis_job_t          job;
  logic [63:0]        rad;
  logic [33:0]        rem_sq;
  logic [31:0]        root;
  logic [31:0]        rem_d;
  logic [55:0]        quo;
  logic signed [31:0] scale;
  logic signed [63:0] prod;
  logic signed [31:0] rd_scale;
  logic signed [31:0] rd_shift;
  logic signed [31:0] scale_mem [MAX_CHANNELS];
  logic signed [31:0] shift_mem [MAX_CHANNELS];

  logic [31:0]        var_sum;
  logic [31:0]        head_ch_w;
  logic [31:0]        job_ch_w;
  logic [35:0]        sq_t;
  logic [35:0]        sq_trial;
  logic               sq_ge;
  logic [31:0]        root_next;
  logic [32:0]        dv_t;
  logic               dv_ge;
  logic [55:0]        quo_next;
  logic [31:0]        gabs;
  logic [31:0]        qlo;
  logic signed [31:0] scale_next;
  logic signed [47:0] prod_hi;
  logic signed [31:0] sum_sat;
  logic signed [31:0] shift_sat;
  logic               out_free;

  assign head_ch_w = 32'(head.ch);
  assign job_ch_w  = 32'(job.ch);
  assign var_sum   = 32'(head.variance_value) + 32'(eps);
  assign pop       = (state == ST_IDLE) && !empty;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    sq_t      = {rem_sq, rad[63:62]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_ge     = sq_t >= sq_trial;
    root_next = {root[30:0], sq_ge};
    dv_t      = {rem_d, quo[55]};
    dv_ge     = dv_t >= {1'b0, root};
    quo_next  = {quo[54:0], dv_ge};
    gabs      = job.gamma_value[31] ? (~job.gamma_value + 32'd1) : job.gamma_value;
    qlo       = {1'b0, quo_next[30:0]};
    if (|quo_next[55:31]) begin
      scale_next = job.gamma_value[31] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      scale_next = job.gamma_value[31] ? (~qlo + 32'd1) : qlo;
    end
    prod_hi   = prod[63:16];
    sum_sat   = sat32(49'(prod_hi) + 49'(rd_shift));
    shift_sat = sat32(49'(job.beta_value) - 49'(prod_hi));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_scale <= scale_mem[head_ch_w[AW-1:0]];
      rd_shift <= shift_mem[head_ch_w[AW-1:0]];
    end
    if (state == ST_SHIFT) begin
      scale_mem[job_ch_w[AW-1:0]] <= scale;
      shift_mem[job_ch_w[AW-1:0]] <= shift_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job    <= head;
      rad    <= {var_sum, 32'd0};
      rem_sq <= '0;
      root   <= '0;
      if (var_sum == 32'd0) begin
        if (head.gamma_value == 32'sd0) begin
          scale <= 32'sd0;
        end else begin
          scale <= head.gamma_value[31] ? 32'sh80000000 : 32'sh7fffffff;
        end
      end
    end
    if (state == ST_SQRT) begin
      rad    <= {rad[61:0], 2'b00};
      rem_sq <= sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
      root   <= root_next;
      quo    <= {gabs, 24'd0};
      rem_d  <= '0;
    end
    if (state == ST_DIV) begin
      rem_d <= dv_ge ? 32'(dv_t - {1'b0, root}) : dv_t[31:0];
      quo   <= quo_next;
      scale <= scale_next;
    end
    if (state == ST_MUL) begin
      prod <= scale * job.mean_value;
    end
    if (state == ST_SMP_MUL) begin
      prod <= job.sample * rd_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (pop) begin
            if (head.mode == MODE_SAMPLE) begin
              state <= ST_SMP_MUL;
            end else if (var_sum == 32'd0) begin
              state <= ST_MUL;
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          step <= step + 6'd1;
          if (step == 6'd31) begin
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 6'd1;
          if (step == 6'd55) begin
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL:     state <= ST_SHIFT;
        ST_SHIFT:   state <= ST_IDLE;
        ST_SMP_MUL: state <= ST_SMP_ADD;
        ST_SMP_ADD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SMP_ADD && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SMP_ADD && out_free) begin
      out_data.normalized  <= sum_sat;
      out_data.out_channel <= job.ch;
      out_data.pixel_end   <= job.pixel_end;
      out_data.frame_end   <= job.frame_end;
    end
  end

endmodule

### hdl/batch_norm_inference_stream_top.sv
// ----------------------------------------------------------------------------
// Batch normalisation for inference, streaming, Q16.16
// Top level: front end, request queue and arithmetic back end.
// ----------------------------------------------------------------------------
// A load request (mode 0) stores one channel's scale and shift; it gives no
// result. A sample request (mode 1) gives one result, sample*scale+shift,
// saturated, with its channel and the end-of-pixel and end-of-frame marks.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. Registers are written through cfg_write, cfg_index and
// cfg_data while the block is idle; the user, not the block, ensures this.
// A sample passes through the back end as table read, multiply, then add and
// saturate; the back end takes the next request from the queue only after
// the result has been offered. A load runs the 32-step square root and the
// 56-step divider, then the multiply and the shift; when variance plus epsilon
// is zero it skips the root and the divider.
// A four-entry queue lets the input keep accepting while the back end works.
// Reset empties the queue and the output register, clears the channel and
// pixel counters and restores the register defaults; the tables keep their
// contents until loaded. When the receiver stalls, the result is held and
// the back end waits before finishing the next sample.
// ----------------------------------------------------------------------------
module batch_norm_inference_stream_top #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bnis_pkg::bnis_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bnis_pkg::bnis_out_t out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [24:0]         cfg_data
);
  import bnis_pkg::*;

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  bnis_job_t   push_job;
  bnis_job_t   head;
  logic [16:0] eps;

  bnis_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .eps       (eps)
  );

  bnis_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  bnis_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .eps       (eps),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/bnis_checker.sv
// ----------------------------------------------------------------------------
// Batch normalisation port checker
// Checks the result channel seen at the top level's ports.
// ----------------------------------------------------------------------------
`include "batch_norm_inference_stream_top_assert.svh"

module bnis_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input bnis_pkg::bnis_out_t out_data
);
  import bnis_pkg::*;

  `BNIS_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "stalled request dropped")
  `BNIS_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_data), "stalled data changed")
  `BNIS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid, "result present after reset")
  `BNIS_ASSERT_SAME(a_frame_pixel, out_valid && out_data.frame_end, out_data.pixel_end, "frame end without pixel end")

endmodule

bind batch_norm_inference_stream_top bnis_checker u_bnis_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/batch_norm_inference_stream_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the streaming batch normalisation block
// Loads channel parameters, streams samples under several register settings
// and compares every result with an independent Q16.16 predictor. Both sides
// idle and stall at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module batch_norm_inference_stream_top_tb;
  import bnis_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 500;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bnis_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  bnis_out_t   out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_CHANNELS;
  logic [24:0] cfg_data = '0;

  logic signed [31:0] scale_tab [64];
  logic signed [31:0] shift_tab [64];
  logic [5:0]   chan_pos;
  logic [23:0]  pix_pos;
  logic [6:0]   chans_reg;
  logic [24:0]  pixels_reg;
  logic [16:0]  eps_reg;
  bnis_out_t    pending_q [$];
  int           fails = 0;
  int           cycles = 0;
  int           stall_pct = 30;
  int           stall_run = 0;
  logic         holding = 1'b0;
  event         hold_off;

  batch_norm_inference_stream_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[batch_norm_inference_stream_top] ERROR");
      $finish;
    end
  end

  // The long receiver hold-off is timed here, apart from the random stalls.
  always begin
    @(hold_off);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void store_params(input bnis_in_t it);
    longint g;
    longint m;
    longint sc;
    longint unsigned v;
    longint unsigned s;
    longint unsigned mag;
    longint unsigned q;
    logic signed [31:0] sc32;
    g = longint'(it.gamma_value);
    m = longint'(it.mean_value);
    v = longint'(it.variance_value) + ((eps_reg > 17'd65536) ? 64'd65536 : longint'(eps_reg));
    if (v == 0) begin
      sc32 = (g > 0) ? 32'sh7fffffff : ((g < 0) ? 32'sh80000000 : 32'sd0);
    end else begin
      s = int_root(v << 32);
      mag = longint'((g < 0) ? -g : g) << 24;
      q = mag / s;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      sc = (g < 0) ? -longint'(q) : longint'(q);
      sc32 = clip32(sc);
    end
    scale_tab[it.channel_index] = sc32;
    shift_tab[it.channel_index] =
        clip32(longint'(it.beta_value) - ((longint'(sc32) * m) >>> 16));
  endfunction

  function automatic bnis_out_t normalise(input bnis_in_t it);
    bnis_out_t r;
    int cl;
    int pl;
    cl = (chans_reg < 1) ? 1 : ((chans_reg > 64) ? 64 : int'(chans_reg));
    pl = (pixels_reg < 1) ? 1 : ((pixels_reg > 25'd16777216) ? 16777216 : int'(pixels_reg));
    r.normalized = clip32(((longint'(it.sample) * longint'(scale_tab[chan_pos])) >>> 16)
                          + longint'(shift_tab[chan_pos]));
    r.out_channel = chan_pos;
    r.pixel_end = (int'(chan_pos) + 1 >= cl);
    r.frame_end = r.pixel_end && (int'(pix_pos) + 1 >= pl);
    if (r.pixel_end) begin
      chan_pos = '0;
      pix_pos = r.frame_end ? 24'd0 : pix_pos + 24'd1;
    end else begin
      chan_pos = chan_pos + 6'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bnis_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.normalized !== want.normalized) begin
          $error("normalized expected %h actual %h", want.normalized, out_data.normalized);
          fails++;
        end
        if (out_data.out_channel !== want.out_channel) begin
          $error("out_channel expected %0d actual %0d", want.out_channel, out_data.out_channel);
          fails++;
        end
        if (out_data.pixel_end !== want.pixel_end) begin
          $error("pixel_end expected %b actual %b", want.pixel_end, out_data.pixel_end);
          fails++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end expected %b actual %b", want.frame_end, out_data.frame_end);
          fails++;
        end
      end
    end
    if (holding) begin
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(49) == 0) stall_run = $urandom_range(60, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one request, waits for the edge that accepts it, then idles the input for the given gap.
  task automatic send_request(input bnis_in_t it, input int gap);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.mode == MODE_LOAD) begin
      store_params(it);
    end else begin
      pending_q.push_back(normalise(it));
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [24:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CHANNELS: chans_reg = val[6:0];
      REG_PIXELS:   pixels_reg = val;
      REG_EPSILON:  eps_reg = val[16:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic bnis_in_t load_req(input logic [5:0] ch, input logic signed [31:0] g,
      input logic signed [31:0] b, input logic signed [31:0] m, input logic [30:0] v);
    bnis_in_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.channel_index = ch;
    it.gamma_value = g;
    it.beta_value = b;
    it.mean_value = m;
    it.variance_value = v;
    it.sample = $urandom;
    return it;
  endfunction

  function automatic bnis_in_t random_load();
    logic signed [31:0] g;
    logic signed [31:0] m;
    logic [30:0] v;
    g = $urandom;
    m = $urandom;
    v = 31'($urandom);
    if ($urandom_range(1)) g = $signed(g) >>> 12;
    if ($urandom_range(1)) m = $signed(m) >>> 10;
    if ($urandom_range(1)) v = v >> $urandom_range(30, 8);
    return load_req(6'($urandom), g, $urandom, m, v);
  endfunction

  function automatic bnis_in_t sample_req(input logic signed [31:0] x);
    bnis_in_t it;
    it.mode = MODE_SAMPLE;
    it.channel_index = 6'($urandom);
    it.gamma_value = $urandom;
    it.beta_value = $urandom;
    it.mean_value = $urandom;
    it.variance_value = 31'($urandom);
    it.sample = x;
    return it;
  endfunction

  task automatic test_defaults();
    for (int c = 0; c < 64; c++) begin
      send_request(load_req(c[5:0], random_load().gamma_value, $urandom,
                            random_load().mean_value, random_load().variance_value), pick_gap());
    end
    repeat (70) send_request(sample_req($urandom), pick_gap());
  endtask

  task automatic test_extremes();
    write_reg(REG_EPSILON, 25'd0);
    write_reg(REG_CHANNELS, 25'd6);
    write_reg(REG_PIXELS, 25'd2);
    send_request(load_req(6'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 31'd0), 0);
    send_request(load_req(6'd1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 31'd0), 0);
    send_request(load_req(6'd2, 32'sd0, 32'sd12345, 32'sh7fffffff, 31'd0), 0);
    send_request(load_req(6'd3, 32'sh7fffffff, 32'sd0, 32'sh7fffffff, 31'd1), 0);
    send_request(load_req(6'd4, 32'sh00010000, 32'sd0, 32'sd0, 31'h7fffffff), 0);
    send_request(load_req(6'd5, 32'shffff0000, 32'sh00008000, 32'sh00010000, 31'h00010000), 0);
    send_request(sample_req(32'sh7fffffff), 0);
    send_request(sample_req(32'sh80000000), 0);
    send_request(sample_req(32'sd0), 0);
    send_request(sample_req(32'sh80000000), 0);
    send_request(sample_req(32'sh7fffffff), 0);
    send_request(sample_req(32'shffffffff), 0);
    repeat (6) send_request(sample_req($urandom), 1);
    write_reg(REG_EPSILON, 25'd65536);
    send_request(load_req(6'd0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'd0), 0);
    write_reg(REG_EPSILON, 25'd131071);
    send_request(load_req(6'd1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff), 0);
    repeat (12) send_request(sample_req($urandom), pick_gap());
  endtask

  task automatic test_limits();
    write_reg(REG_CHANNELS, 25'd127);
    write_reg(REG_PIXELS, 25'h1ffffff);
    repeat (70) send_request(sample_req($urandom), 0);
    write_reg(REG_CHANNELS, 25'd0);
    write_reg(REG_PIXELS, 25'd0);
    repeat (4) send_request(sample_req($urandom), 0);
    write_reg(REG_NONE, 25'h1ffffff);
    write_reg(REG_CHANNELS, 25'd8);
    write_reg(REG_PIXELS, 25'd5);
    repeat (13) send_request(sample_req($urandom), 0);
    write_reg(REG_CHANNELS, 25'd3);
    write_reg(REG_PIXELS, 25'd1);
    repeat (8) send_request(sample_req($urandom), pick_gap());
    write_reg(REG_CHANNELS, 25'd64);
    write_reg(REG_PIXELS, 25'd16777216);
    repeat (20) send_request(sample_req($urandom), 0);
  endtask

  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      stall_pct = (p == 2) ? 0 : $urandom_range(60, 5);
      write_reg(REG_CHANNELS,
                $urandom_range(1) ? 25'($urandom_range(64, 1)) : 25'($urandom_range(127)));
      write_reg(REG_PIXELS, $urandom_range(3) ? 25'($urandom_range(8)) : 25'($urandom));
      write_reg(REG_EPSILON,
                $urandom_range(3) ? 25'($urandom_range(200)) : 25'($urandom_range(131071)));
      repeat (120) begin
        if ($urandom_range(9) == 0) send_request(random_load(), pick_gap());
        else send_request(sample_req($urandom), (p == 2) ? 0 : pick_gap());
      end
    end
  endtask

  task automatic test_backpressure();
    stall_pct = 10;
    drain();
    -> hold_off;
    repeat (40) send_request(sample_req($urandom), 0);
  endtask

  initial begin
    chan_pos = '0;
    pix_pos = '0;
    chans_reg = 7'd64;
    pixels_reg = 25'd1;
    eps_reg = 17'd66;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_limits();
    test_random();
    test_backpressure();
    drain();
    if (fails == 0) begin
      $display("[batch_norm_inference_stream_top] OK");
    end else begin
      $display("[batch_norm_inference_stream_top] ERROR");
    end
    $finish;
  end

endmodule
